>>> hw/rtl/spq_pkg.sv
// Shared types for the sorted priority queue: action codes, status codes and
// the control token that walks the cell chain. No dependencies.
package spq_pkg;

    localparam int VALUE_W       = 32;
    localparam int ACTION_W      = 2;
    localparam int STATUS_W      = 2;
    localparam int MATCH_POS_W   = 4;
    localparam int COUNT_W       = 5;
    localparam int DEF_CAPACITY  = 16;

    typedef enum logic [ACTION_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE    = 2'd0,
        STATUS_MISSING = 2'd1,
        STATUS_FULL    = 2'd2
    } status_t;

    // control part of the token handed from cell to cell
    typedef struct packed {
        logic valid;
        op_t  op;
        logic full;   // insert rejected, cells leave their entries alone
        logic found;  // a cell upstream matched the value
    } tok_t;

endpackage

>>> hw/rtl/spq_cell.sv
// One storage cell of the sorted priority queue chain.
// Depends on spq_pkg for the token type and operation codes.
module spq_cell #(
    parameter int CAPACITY = spq_pkg::DEF_CAPACITY,
    parameter int INDEX    = 0,
    parameter int PW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  spq_pkg::tok_t                tok_in,
    input  logic [spq_pkg::VALUE_W-1:0]  carry_in,
    input  logic [PW-1:0]                pos_in,
    input  logic [spq_pkg::VALUE_W-1:0]  next_entry,
    input  logic [CW-1:0]                occupancy,
    output spq_pkg::tok_t                tok_out,
    output logic [spq_pkg::VALUE_W-1:0]  carry_out,
    output logic [PW-1:0]                pos_out,
    output logic [spq_pkg::VALUE_W-1:0]  entry
);
    import spq_pkg::*;

    localparam logic [CW-1:0] MY_SLOT = CW'(INDEX);
    localparam logic [PW-1:0] MY_POS  = PW'(INDEX);

    logic [VALUE_W-1:0] entry_reg, entry_next;
    tok_t               tok_reg, tok_next;
    logic [VALUE_W-1:0] carry_reg, carry_next;
    logic [PW-1:0]      pos_reg, pos_next;

    logic occupied, at_tail, ge, eq;

    assign occupied = MY_SLOT < occupancy;
    assign at_tail  = MY_SLOT == occupancy;
    assign ge       = $signed(carry_in) >= $signed(entry_reg);
    assign eq       = carry_in == entry_reg;

    always_comb begin
        entry_next = entry_reg;
        tok_next   = tok_in;
        carry_next = carry_in;
        pos_next   = pos_in;
        if (tok_in.valid) begin
            case (tok_in.op)
                OP_INSERT: begin
                    // swap in the carried value, pass the displaced one on
                    if (!tok_in.full) begin
                        if (occupied && ge) begin
                            entry_next = carry_in;
                            carry_next = entry_reg;
                        end else if (at_tail) begin
                            entry_next = carry_in;
                        end
                    end
                end
                OP_REMOVE: begin
                    // from the first match on, pull up the next entry
                    if (occupied && (tok_in.found || eq)) begin
                        entry_next = next_entry;
                        if (!tok_in.found) begin
                            tok_next.found = 1'b1;
                            pos_next       = MY_POS;
                        end
                    end
                end
                OP_FIND: begin
                    if (occupied && !tok_in.found && eq) begin
                        tok_next.found = 1'b1;
                        pos_next       = MY_POS;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        carry_reg <= carry_next;
        pos_reg   <= pos_next;
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign entry     = entry_reg;
    assign tok_out   = tok_reg;
    assign carry_out = carry_reg;
    assign pos_out   = pos_reg;

endmodule

>>> hw/rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: stream ports, token injection,
// result capture and the chain of spq_cell instances. Depends on spq_pkg.
//
// The queue keeps up to CAPACITY signed 32-bit values in descending order,
// largest at the head, one value per cell. Each input transaction carries an
// action (insert, remove first equal entry, find) and a value; each produces
// exactly one result transaction with status, match flag and position, and
// the head value, non-empty flag and entry count after the action. The
// action enters as a token at the head cell and moves one cell per clock;
// each cell compares the token value with its own entry and, for insert or
// remove, trades entries with the token or with its downstream neighbor.
// An item is accepted, walks all CAPACITY cells and its result is captured
// and handed to the output register before the next item is accepted; that
// hand-off waits while the output register still holds an untaken result.
// s_axis_tready is low while an item is in flight. One finished result
// can wait in the output register while the next item walks the chain.
// Insert into a full queue is rejected with status full. Entries start
// undefined; only occupied cells are ever reported.
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] item_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] found, [4:1] match_position, [5] head_valid, [37:6] head_value,
    // [42:38] entry_count, [47:43] zero
    output logic [47:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import spq_pkg::*;

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_ENTRY  = CW'(1);

    // chain wiring, slot 0 is the injection register
    tok_t               tok   [CAPACITY+1];
    logic [VALUE_W-1:0] carry [CAPACITY+1];
    logic [PW-1:0]      pos   [CAPACITY+1];
    logic [VALUE_W-1:0] entry [CAPACITY];

    logic [CW-1:0] occ_reg, occ_next;
    logic          busy_reg, busy_next;
    tok_t          inj_tok_reg, inj_tok_next;
    logic [VALUE_W-1:0] inj_value_reg;

    // finished item waiting for the output register
    logic               pend_valid_reg, pend_valid_next;
    status_t            pend_status_reg, pend_status_next;
    logic               pend_found_reg, pend_found_next;
    logic [MATCH_POS_W-1:0] pend_pos_reg, pend_pos_next;
    logic               pend_hvalid_reg, pend_hvalid_next;
    logic [VALUE_W-1:0] pend_head_reg, pend_head_next;
    logic [COUNT_W-1:0] pend_count_reg, pend_count_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg;
    logic               m_found_reg;
    logic [MATCH_POS_W-1:0] m_pos_reg;
    logic               m_hvalid_reg;
    logic [VALUE_W-1:0] m_head_reg;
    logic [COUNT_W-1:0] m_count_reg;

    logic    accept, finish, move_out;
    op_t     in_op;
    tok_t    last_tok;
    logic [CW-1:0] occ_after;

    assign s_axis_tready = !busy_reg;
    assign accept        = s_axis_tvalid && !busy_reg;
    assign in_op         = op_t'(s_axis_tuser);
    assign last_tok      = tok[CAPACITY];
    assign finish        = last_tok.valid;
    assign move_out      = pend_valid_reg && (!m_valid_reg || m_axis_tready);

    assign tok[0]   = inj_tok_reg;
    assign carry[0] = inj_value_reg;
    assign pos[0]   = '0;

    generate
        for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
            logic [VALUE_W-1:0] nbr;
            if (i < CAPACITY - 1) begin : g_mid
                assign nbr = entry[i+1];
            end else begin : g_end
                // last cell has no downstream neighbor; it is vacated anyway
                assign nbr = entry[i];
            end
            spq_cell #(
                .CAPACITY (CAPACITY),
                .INDEX    (i),
                .PW       (PW),
                .CW       (CW)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .tok_in     (tok[i]),
                .carry_in   (carry[i]),
                .pos_in     (pos[i]),
                .next_entry (nbr),
                .occupancy  (occ_reg),
                .tok_out    (tok[i+1]),
                .carry_out  (carry[i+1]),
                .pos_out    (pos[i+1]),
                .entry      (entry[i])
            );
        end
    endgenerate

    // token for a new transaction; a full insert walks as a no-op
    always_comb begin
        inj_tok_next       = '0;
        inj_tok_next.valid = accept;
        inj_tok_next.op    = in_op;
        inj_tok_next.full  = (in_op == OP_INSERT) && (occ_reg >= FULL_COUNT);
        inj_tok_next.found = 1'b0;
    end

    // occupancy once the token has left the last cell
    always_comb begin
        occ_after = occ_reg;
        case (last_tok.op)
            OP_INSERT: if (!last_tok.full)  occ_after = occ_reg + ONE_ENTRY;
            OP_REMOVE: if (last_tok.found)  occ_after = occ_reg - ONE_ENTRY;
            default: begin
            end
        endcase
    end

    always_comb begin
        occ_next         = occ_reg;
        busy_next        = busy_reg;
        pend_valid_next  = pend_valid_reg;
        pend_status_next = pend_status_reg;
        pend_found_next  = pend_found_reg;
        pend_pos_next    = pend_pos_reg;
        pend_hvalid_next = pend_hvalid_reg;
        pend_head_next   = pend_head_reg;
        pend_count_next  = pend_count_reg;
        m_valid_next     = m_valid_reg;

        if (accept) begin
            busy_next = 1'b1;
        end

        if (finish) begin
            occ_next        = occ_after;
            pend_valid_next = 1'b1;
            pend_found_next = last_tok.found;
            pend_pos_next   = last_tok.found ? MATCH_POS_W'(pos[CAPACITY]) : '0;
            pend_hvalid_next = occ_after != '0;
            pend_head_next  = (occ_after != '0) ? entry[0] : '0;
            pend_count_next = COUNT_W'(occ_after);
            case (last_tok.op)
                OP_INSERT: pend_status_next = last_tok.full ? STATUS_FULL : STATUS_DONE;
                OP_REMOVE,
                OP_FIND:   pend_status_next = last_tok.found ? STATUS_DONE
                                                             : STATUS_MISSING;
                default:   pend_status_next = STATUS_DONE;
            endcase
        end

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (move_out) begin
            m_valid_next    = 1'b1;
            pend_valid_next = 1'b0;
            busy_next       = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        inj_value_reg   <= s_axis_tdata;
        pend_status_reg <= pend_status_next;
        pend_found_reg  <= pend_found_next;
        pend_pos_reg    <= pend_pos_next;
        pend_hvalid_reg <= pend_hvalid_next;
        pend_head_reg   <= pend_head_next;
        pend_count_reg  <= pend_count_next;
        if (move_out) begin
            m_status_reg <= pend_status_reg;
            m_found_reg  <= pend_found_reg;
            m_pos_reg    <= pend_pos_reg;
            m_hvalid_reg <= pend_hvalid_reg;
            m_head_reg   <= pend_head_reg;
            m_count_reg  <= pend_count_reg;
        end
        if (!aresetn) begin
            occ_reg        <= '0;
            busy_reg       <= 1'b0;
            inj_tok_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            occ_reg        <= occ_next;
            busy_reg       <= busy_next;
            inj_tok_reg    <= inj_tok_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {5'd0, m_count_reg, m_head_reg, m_hvalid_reg,
                            m_pos_reg, m_found_reg};

endmodule
